// ----- sv/sgi3_pkg.sv -----
`timescale 1ns / 1ps
// shared constants for the 3d line closest-approach intersection block
package sgi3_pkg;

  localparam int TOL_W      = 16;
  localparam int MODE_W     = 2;
  localparam int CFG_IDX_W  = 2;
  localparam int PARAM_W    = 32;
  localparam int PARAM_FRAC = 16;

  // test modes
  localparam logic [MODE_W-1:0] MODE_LINE     = 2'd0;
  localparam logic [MODE_W-1:0] MODE_SEG_LINE = 2'd1;
  localparam logic [MODE_W-1:0] MODE_SEG_SEG  = 2'd2;

  // register indexes
  localparam logic [CFG_IDX_W-1:0] REG_TEST_MODE  = 2'd0;
  localparam logic [CFG_IDX_W-1:0] REG_TOL_FIRST  = 2'd1;
  localparam logic [CFG_IDX_W-1:0] REG_TOL_SECOND = 2'd2;

  // register reset values
  localparam logic [MODE_W-1:0] MODE_RESET       = MODE_SEG_SEG;
  localparam logic [TOL_W-1:0]  TOL_FIRST_RESET  = 16'd0;
  localparam logic [TOL_W-1:0]  TOL_SECOND_RESET = 16'd3;

  // cyclic neighbors for cross products
  localparam int NEXT1 [3] = '{1, 2, 0};
  localparam int NEXT2 [3] = '{2, 0, 1};

endpackage

// ----- sv/sgi3_div.sv -----
`timescale 1ns / 1ps
// pipelined restoring divider, one quotient bit per stage, saturating quotient
module sgi3_div #(
  parameter int NUMW  = 91,
  parameter int DENW  = 64,
  parameter int QBITS = 33
) (
  input  logic              clk,
  input  logic              adv,
  input  logic [NUMW-1:0]   num,
  input  logic [DENW-1:0]   den,
  output logic [QBITS:0]    quot
);

  localparam int HW = NUMW - QBITS;
  localparam int MW = (HW > DENW) ? HW : DENW;

  logic [DENW-1:0]  rem  [QBITS+1];
  logic [QBITS-1:0] low  [QBITS+1];
  logic [DENW-1:0]  dval [QBITS+1];
  logic [QBITS-1:0] q    [QBITS+1];
  logic             ovf  [QBITS+1];

  for (genvar k = 0; k <= QBITS; k++) begin : g_stage
    if (k == 0) begin : g_head
      logic over;
      // quotient would not fit: high part already reaches the divisor
      assign over = MW'(num[NUMW-1:QBITS]) >= MW'(den);
      always_ff @(posedge clk) begin
        if (adv) begin
          ovf[k]  <= over;
          rem[k]  <= over ? '0 : DENW'(num[NUMW-1:QBITS]);
          low[k]  <= num[QBITS-1:0];
          dval[k] <= den;
          q[k]    <= '0;
        end
      end
    end else begin : g_bit
      localparam int BI = QBITS - k;
      logic [DENW:0] trial;
      logic          ge;
      assign trial = {rem[k-1], low[k-1][BI]};
      assign ge    = trial >= {1'b0, dval[k-1]};
      always_ff @(posedge clk) begin
        if (adv) begin
          ovf[k]  <= ovf[k-1];
          rem[k]  <= ge ? DENW'(trial - {1'b0, dval[k-1]}) : DENW'(trial);
          low[k]  <= low[k-1];
          dval[k] <= dval[k-1];
          q[k]    <= q[k-1] | (QBITS'(ge) << BI);
        end
      end
    end
  end

  assign quot = ovf[QBITS] ? {1'b1, QBITS'(0)} : {1'b0, q[QBITS]};

endmodule

// ----- sv/segment_intersect_3d.sv -----
`timescale 1ns / 1ps
// top level: pipelined closest-approach intersection test of two 3d lines
//
//  channel   | handshake             | payload
//  ----------+-----------------------+---------------------------------------------
//  input     | in_valid / in_stall   | a_origin_*, a_dir_*, b_origin_*, b_dir_*
//  output    | out_valid / out_stall | hit, lines_close, degenerate, param_a, param_b
//  config    | cfg_we                | cfg_index, cfg_data
//
//  one transfer per cycle in each direction while no finished result is held;
//  the depth is set by the root pipeline and the divider depth
//  rst is synchronous and clears the valid chain and the registers
//  one global advance: a stalled result freezes every stage, nothing drops
//  register writes must be made while the pipeline is empty; the block does not enforce it
module segment_intersect_3d #(
  parameter int COORD_WIDTH = 16,
  parameter int FRAC_BITS   = 8
) (
  input  logic                                clk,
  input  logic                                rst,
  input  logic                                in_valid,
  output logic                                in_stall,
  input  logic signed [COORD_WIDTH-1:0]       a_origin_x,
  input  logic signed [COORD_WIDTH-1:0]       a_origin_y,
  input  logic signed [COORD_WIDTH-1:0]       a_origin_z,
  input  logic signed [COORD_WIDTH-1:0]       a_dir_x,
  input  logic signed [COORD_WIDTH-1:0]       a_dir_y,
  input  logic signed [COORD_WIDTH-1:0]       a_dir_z,
  input  logic signed [COORD_WIDTH-1:0]       b_origin_x,
  input  logic signed [COORD_WIDTH-1:0]       b_origin_y,
  input  logic signed [COORD_WIDTH-1:0]       b_origin_z,
  input  logic signed [COORD_WIDTH-1:0]       b_dir_x,
  input  logic signed [COORD_WIDTH-1:0]       b_dir_y,
  input  logic signed [COORD_WIDTH-1:0]       b_dir_z,
  output logic                                out_valid,
  input  logic                                out_stall,
  output logic                                hit,
  output logic                                lines_close,
  output logic                                degenerate,
  output logic signed [sgi3_pkg::PARAM_W-1:0] param_a,
  output logic signed [sgi3_pkg::PARAM_W-1:0] param_b,
  input  logic                                cfg_we,
  input  logic [sgi3_pkg::CFG_IDX_W-1:0]      cfg_index,
  input  logic [sgi3_pkg::TOL_W-1:0]          cfg_data
);

  // widths follow from the coordinate format
  localparam int C     = COORD_WIDTH;
  localparam int PS    = sgi3_pkg::PARAM_FRAC - FRAC_BITS;
  localparam int WW    = C + 1;          // origin difference
  localparam int PRW   = 2 * C;          // direction products
  localparam int SQW   = 2 * C;          // direction squares
  localparam int XW    = 2 * C + 2 * PS; // radicand
  localparam int LENW  = C + PS;         // direction length, Q8.16
  localparam int NCW   = 2 * C + 1;      // normal component
  localparam int CRW   = 2 * C + 1;      // w x d products
  localparam int CBW   = 2 * C + 2;      // w x d component
  localparam int NNPW  = 2 * NCW;        // normal squares
  localparam int NNW   = 4 * C;          // |n|^2
  localparam int NWPW  = NCW + WW;       // n.w products
  localparam int NWW   = 3 * C + 3;      // n.w
  localparam int NWAW  = 3 * C + 2;      // |n.w|
  localparam int NUMPW = CBW + NCW;      // numerator products
  localparam int NUMW  = 4 * C + 2;      // numerator
  localparam int NUMAW = 4 * C + 1;      // |numerator|
  localparam int EPSW  = sgi3_pkg::TOL_W + 1;
  localparam int EPS2W = 2 * EPSW;
  localparam int CMPA  = 2 * NWAW;
  localparam int CMPB  = EPS2W + NNW;
  localparam int CMPW  = (CMPA > CMPB) ? CMPA : CMPB;
  localparam int PRODW = NUMAW + LENW;
  localparam int QBASE = (LENW > sgi3_pkg::TOL_W + PS) ? LENW : sgi3_pkg::TOL_W + PS;
  localparam int QC    = ((QBASE > sgi3_pkg::PARAM_W - 1) ? QBASE : sgi3_pkg::PARAM_W - 1) + 2;
  localparam int PAW   = QC + 2;
  localparam int DLY   = LENW - 6;       // waits for the root pipeline
  localparam int NST   = LENW + QC + 6;  // register stages input to output

  // split operands so that no single product gets wide
  localparam int NWL   = NWAW / 2;       // low half of |n.w|
  localparam int NWH   = NWAW - NWL;
  localparam int HHW   = 2 * NWH;
  localparam int HLW   = NWH + NWL;
  localparam int LLW   = 2 * NWL;
  localparam int NNL   = NNW / 2;        // low half of |n|^2
  localparam int NNH   = NNW - NNL;
  localparam int EHW   = EPS2W + NNH;
  localparam int ELW   = EPS2W + NNL;
  localparam int NUML  = NUMAW / 2;      // low half of |numerator|
  localparam int NUMH  = NUMAW - NUML;
  localparam int PHW   = NUMH + LENW;
  localparam int PLW   = NUML + LENW;

  typedef struct packed {
    logic             close;
    logic             degen;
    logic             neg_a;
    logic             neg_b;
    logic [NUMAW-1:0] num_a;
    logic [NUMAW-1:0] num_b;
    logic [NNW-1:0]   nn;
  } mid_t;

  typedef struct packed {
    logic            close;
    logic            degen;
    logic            neg_a;
    logic            neg_b;
    logic [LENW-1:0] len_a;
    logic [LENW-1:0] len_b;
  } side_t;

  // configuration
  logic [sgi3_pkg::MODE_W-1:0] test_mode;
  logic [sgi3_pkg::TOL_W-1:0]  tol_first;
  logic [sgi3_pkg::TOL_W-1:0]  tol_second;
  logic [EPSW-1:0]             eps_sum;
  logic [EPS2W-1:0]            eps_sq;

  always_ff @(posedge clk) begin
    if (rst) begin
      test_mode  <= sgi3_pkg::MODE_RESET;
      tol_first  <= sgi3_pkg::TOL_FIRST_RESET;
      tol_second <= sgi3_pkg::TOL_SECOND_RESET;
    end else if (cfg_we) begin
      unique case (cfg_index)
        sgi3_pkg::REG_TEST_MODE:  test_mode  <= cfg_data[sgi3_pkg::MODE_W-1:0];
        sgi3_pkg::REG_TOL_FIRST:  tol_first  <= cfg_data;
        sgi3_pkg::REG_TOL_SECOND: tol_second <= cfg_data;
        default: ;
      endcase
    end
  end

  // squared tolerance sum, settled long before an item needs it
  assign eps_sum = EPSW'(tol_first) + EPSW'(tol_second);
  always_ff @(posedge clk) begin
    eps_sq <= EPS2W'(eps_sum) * EPS2W'(eps_sum);
  end

  // global advance: everything moves unless a finished result is held
  logic           adv;
  logic [NST-1:0] vld;

  assign adv       = !(out_valid && out_stall);
  assign in_stall  = !adv;
  assign out_valid = vld[NST-1];

  always_ff @(posedge clk) begin
    if (rst) begin
      vld <= '0;
    end else if (adv) begin
      vld <= {vld[NST-2:0], in_valid};
    end
  end

  // input vectors
  logic signed [C-1:0] oa [3];
  logic signed [C-1:0] da [3];
  logic signed [C-1:0] ob [3];
  logic signed [C-1:0] db [3];

  assign oa[0] = a_origin_x;
  assign oa[1] = a_origin_y;
  assign oa[2] = a_origin_z;
  assign da[0] = a_dir_x;
  assign da[1] = a_dir_y;
  assign da[2] = a_dir_z;
  assign ob[0] = b_origin_x;
  assign ob[1] = b_origin_y;
  assign ob[2] = b_origin_z;
  assign db[0] = b_dir_x;
  assign db[1] = b_dir_y;
  assign db[2] = b_dir_z;

  // stage registers
  logic signed [WW-1:0]    s1_w   [3];
  logic signed [C-1:0]     s1_da  [3];
  logic signed [C-1:0]     s1_db  [3];
  logic signed [PRW-1:0]   s1_pn  [3][2];
  logic [SQW-1:0]          s1_sqa [3];
  logic [SQW-1:0]          s1_sqb [3];

  logic signed [WW-1:0]    s2_w   [3];
  logic signed [NCW-1:0]   s2_n   [3];
  logic [XW-1:0]           s2_x   [2];
  logic signed [CRW-1:0]   s2_pcb [3][2];
  logic signed [CRW-1:0]   s2_pca [3][2];

  logic signed [NCW-1:0]   s3_n   [3];
  logic signed [NNPW-1:0]  s3_pnn [3];
  logic signed [NWPW-1:0]  s3_pnw [3];
  logic signed [CBW-1:0]   s3_cb  [3];
  logic signed [CBW-1:0]   s3_ca  [3];

  logic [NNW-1:0]          s4_nn;
  logic signed [NWW-1:0]   s4_nw;
  logic signed [NUMPW-1:0] s4_pna [3];
  logic signed [NUMPW-1:0] s4_pnb [3];

  logic [NNW-1:0]          s5_nn;
  logic [NWAW-1:0]         s5_nwabs;
  logic signed [NUMW-1:0]  s5_num_a;
  logic signed [NUMW-1:0]  s5_num_b;

  logic [NNW-1:0]          s6_nn;
  logic [HHW-1:0]          s6_nw_hh;
  logic [HLW-1:0]          s6_nw_hl;
  logic [LLW-1:0]          s6_nw_ll;
  logic [EHW-1:0]          s6_enn_hi;
  logic [ELW-1:0]          s6_enn_lo;
  logic [NUMAW-1:0]        s6_num_a;
  logic [NUMAW-1:0]        s6_num_b;
  logic                    s6_neg_a;
  logic                    s6_neg_b;

  logic [NNW-1:0]          s7_nn;
  logic [CMPW-1:0]         s7_nw2;
  logic [CMPW-1:0]         s7_e2nn;
  logic [NUMAW-1:0]        s7_num_a;
  logic [NUMAW-1:0]        s7_num_b;
  logic                    s7_neg_a;
  logic                    s7_neg_b;

  mid_t                    mid_q  [DLY+1];
  logic [PHW-1:0]          pp_a_hi;
  logic [PLW-1:0]          pp_a_lo;
  logic [PHW-1:0]          pp_b_hi;
  logic [PLW-1:0]          pp_b_lo;
  logic [NNW-1:0]          pp_nn;
  logic [PRODW-1:0]        sm_prod_a;
  logic [PRODW-1:0]        sm_prod_b;
  logic [NNW-1:0]          sm_nn;
  side_t                   side_q [QC+3];

  logic [LENW-1:0]         len_a;
  logic [LENW-1:0]         len_b;

  always_ff @(posedge clk) begin
    if (adv) begin
      // s1: origin difference, direction products and squares
      for (int i = 0; i < 3; i++) begin
        s1_w[i]     <= WW'(ob[i]) - WW'(oa[i]);
        s1_da[i]    <= da[i];
        s1_db[i]    <= db[i];
        s1_pn[i][0] <= PRW'(da[sgi3_pkg::NEXT1[i]]) * PRW'(db[sgi3_pkg::NEXT2[i]]);
        s1_pn[i][1] <= PRW'(da[sgi3_pkg::NEXT2[i]]) * PRW'(db[sgi3_pkg::NEXT1[i]]);
        s1_sqa[i]   <= SQW'(PRW'(da[i]) * PRW'(da[i]));
        s1_sqb[i]   <= SQW'(PRW'(db[i]) * PRW'(db[i]));
      end

      // s2: normal, radicands, w x d products
      s2_x[0] <= (XW'(s1_sqa[0]) + XW'(s1_sqa[1]) + XW'(s1_sqa[2])) << (2 * PS);
      s2_x[1] <= (XW'(s1_sqb[0]) + XW'(s1_sqb[1]) + XW'(s1_sqb[2])) << (2 * PS);
      for (int i = 0; i < 3; i++) begin
        s2_w[i]      <= s1_w[i];
        s2_n[i]      <= NCW'(s1_pn[i][0]) - NCW'(s1_pn[i][1]);
        s2_pcb[i][0] <= CRW'(s1_w[sgi3_pkg::NEXT1[i]]) * CRW'(s1_db[sgi3_pkg::NEXT2[i]]);
        s2_pcb[i][1] <= CRW'(s1_w[sgi3_pkg::NEXT2[i]]) * CRW'(s1_db[sgi3_pkg::NEXT1[i]]);
        s2_pca[i][0] <= CRW'(s1_w[sgi3_pkg::NEXT1[i]]) * CRW'(s1_da[sgi3_pkg::NEXT2[i]]);
        s2_pca[i][1] <= CRW'(s1_w[sgi3_pkg::NEXT2[i]]) * CRW'(s1_da[sgi3_pkg::NEXT1[i]]);
      end

      // s3: |n|^2 and n.w terms, w x d
      for (int i = 0; i < 3; i++) begin
        s3_n[i]   <= s2_n[i];
        s3_pnn[i] <= NNPW'(s2_n[i]) * NNPW'(s2_n[i]);
        s3_pnw[i] <= NWPW'(s2_n[i]) * NWPW'(s2_w[i]);
        s3_cb[i]  <= CBW'(s2_pcb[i][0]) - CBW'(s2_pcb[i][1]);
        s3_ca[i]  <= CBW'(s2_pca[i][0]) - CBW'(s2_pca[i][1]);
      end

      // s4: sums and numerator terms
      s4_nn <= NNW'(s3_pnn[0] + s3_pnn[1] + s3_pnn[2]);
      s4_nw <= NWW'(s3_pnw[0]) + NWW'(s3_pnw[1]) + NWW'(s3_pnw[2]);
      for (int i = 0; i < 3; i++) begin
        s4_pna[i] <= NUMPW'(s3_cb[i]) * NUMPW'(s3_n[i]);
        s4_pnb[i] <= NUMPW'(s3_ca[i]) * NUMPW'(s3_n[i]);
      end

      // s5: numerators, |n.w|
      s5_nn    <= s4_nn;
      s5_nwabs <= NWAW'(s4_nw[NWW-1] ? -s4_nw : s4_nw);
      s5_num_a <= NUMW'(s4_pna[0]) + NUMW'(s4_pna[1]) + NUMW'(s4_pna[2]);
      s5_num_b <= NUMW'(s4_pnb[0]) + NUMW'(s4_pnb[1]) + NUMW'(s4_pnb[2]);

      // s6: partial products of the squared distance test, numerator magnitudes
      s6_nn     <= s5_nn;
      s6_nw_hh  <= HHW'(s5_nwabs[NWAW-1:NWL]) * HHW'(s5_nwabs[NWAW-1:NWL]);
      s6_nw_hl  <= HLW'(s5_nwabs[NWAW-1:NWL]) * HLW'(s5_nwabs[NWL-1:0]);
      s6_nw_ll  <= LLW'(s5_nwabs[NWL-1:0]) * LLW'(s5_nwabs[NWL-1:0]);
      s6_enn_hi <= EHW'(eps_sq) * EHW'(s5_nn[NNW-1:NNL]);
      s6_enn_lo <= ELW'(eps_sq) * ELW'(s5_nn[NNL-1:0]);
      s6_neg_a  <= s5_num_a[NUMW-1];
      s6_neg_b  <= s5_num_b[NUMW-1];
      s6_num_a  <= NUMAW'(s5_num_a[NUMW-1] ? -s5_num_a : s5_num_a);
      s6_num_b  <= NUMAW'(s5_num_b[NUMW-1] ? -s5_num_b : s5_num_b);

      // s7: combine the partial products
      s7_nn    <= s6_nn;
      s7_nw2   <= (CMPW'(s6_nw_hh) << (2 * NWL)) + (CMPW'(s6_nw_hl) << (NWL + 1)) +
                  CMPW'(s6_nw_ll);
      s7_e2nn  <= (CMPW'(s6_enn_hi) << NNL) + CMPW'(s6_enn_lo);
      s7_neg_a <= s6_neg_a;
      s7_neg_b <= s6_neg_b;
      s7_num_a <= s6_num_a;
      s7_num_b <= s6_num_b;

      // s8: closeness and degenerate flags, then wait for the lengths
      mid_q[0].close <= s7_nw2 < s7_e2nn;
      mid_q[0].degen <= s7_nn == '0;
      mid_q[0].neg_a <= s7_neg_a;
      mid_q[0].neg_b <= s7_neg_b;
      mid_q[0].num_a <= s7_num_a;
      mid_q[0].num_b <= s7_num_b;
      mid_q[0].nn    <= s7_nn;
      for (int j = 1; j <= DLY; j++) begin
        mid_q[j] <= mid_q[j-1];
      end

      // numerator times length in two halves, then summed for the dividers
      pp_a_hi          <= PHW'(mid_q[DLY].num_a[NUMAW-1:NUML]) * PHW'(len_a);
      pp_a_lo          <= PLW'(mid_q[DLY].num_a[NUML-1:0]) * PLW'(len_a);
      pp_b_hi          <= PHW'(mid_q[DLY].num_b[NUMAW-1:NUML]) * PHW'(len_b);
      pp_b_lo          <= PLW'(mid_q[DLY].num_b[NUML-1:0]) * PLW'(len_b);
      pp_nn            <= mid_q[DLY].nn;
      sm_prod_a        <= (PRODW'(pp_a_hi) << NUML) + PRODW'(pp_a_lo);
      sm_prod_b        <= (PRODW'(pp_b_hi) << NUML) + PRODW'(pp_b_lo);
      sm_nn            <= pp_nn;
      side_q[0].close  <= mid_q[DLY].close;
      side_q[0].degen  <= mid_q[DLY].degen;
      side_q[0].neg_a  <= mid_q[DLY].neg_a;
      side_q[0].neg_b  <= mid_q[DLY].neg_b;
      side_q[0].len_a  <= len_a;
      side_q[0].len_b  <= len_b;
      for (int j = 1; j <= QC + 2; j++) begin
        side_q[j] <= side_q[j-1];
      end
    end
  end

  // direction lengths: bit-per-stage square root, both lanes side by side
  logic [XW-1:0]   sq_rem  [2][LENW];
  logic [LENW-1:0] sq_root [2][LENW];

  for (genvar l = 0; l < 2; l++) begin : g_lane
    for (genvar s = 0; s < LENW; s++) begin : g_sq
      localparam int B = LENW - 1 - s;
      logic [XW-1:0]   rem_in;
      logic [LENW-1:0] root_in;
      logic [XW-1:0]   trial;
      if (s == 0) begin : g_first
        assign rem_in  = s2_x[l];
        assign root_in = '0;
      end else begin : g_next
        assign rem_in  = sq_rem[l][s-1];
        assign root_in = sq_root[l][s-1];
      end
      // (r + 2^b)^2 - r^2
      assign trial = (XW'(root_in) << (B + 1)) | (XW'(1) << (2 * B));
      always_ff @(posedge clk) begin
        if (adv) begin
          if (trial <= rem_in) begin
            sq_rem[l][s]  <= rem_in - trial;
            sq_root[l][s] <= root_in | (LENW'(1) << B);
          end else begin
            sq_rem[l][s]  <= rem_in;
            sq_root[l][s] <= root_in;
          end
        end
      end
    end
  end

  assign len_a = sq_root[0][LENW-1];
  assign len_b = sq_root[1][LENW-1];

  // parameter magnitudes, capped at 2^QC
  logic [QC:0] quot_a;
  logic [QC:0] quot_b;

  sgi3_div #(
    .NUMW  (PRODW),
    .DENW  (NNW),
    .QBITS (QC)
  ) u_div_a (
    .clk  (clk),
    .adv  (adv),
    .num  (sm_prod_a),
    .den  (sm_nn),
    .quot (quot_a)
  );

  sgi3_div #(
    .NUMW  (PRODW),
    .DENW  (NNW),
    .QBITS (QC)
  ) u_div_b (
    .clk  (clk),
    .adv  (adv),
    .num  (sm_prod_b),
    .den  (sm_nn),
    .quot (quot_b)
  );

  // range tests and saturation on the last stage
  side_t                          fin;
  logic [PAW-1:0]                 mag_a;
  logic [PAW-1:0]                 mag_b;
  logic signed [PAW-1:0]          pa;
  logic signed [PAW-1:0]          pb;
  logic signed [PAW-1:0]          ea;
  logic signed [PAW-1:0]          eb;
  logic signed [PAW-1:0]          la;
  logic signed [PAW-1:0]          lb;
  logic                           in_a;
  logic                           in_a_wide;
  logic                           in_b;
  logic                           hit_next;
  logic [sgi3_pkg::PARAM_W-1:0]   sat_a;
  logic [sgi3_pkg::PARAM_W-1:0]   sat_b;

  assign fin   = side_q[QC+2];
  assign mag_a = PAW'(quot_a);
  assign mag_b = PAW'(quot_b);
  assign pa    = fin.neg_a ? PAW'(-mag_a) : mag_a;
  assign pb    = fin.neg_b ? PAW'(-mag_b) : mag_b;
  assign ea    = PAW'(tol_first) << PS;
  assign eb    = PAW'(tol_second) << PS;
  assign la    = PAW'(fin.len_a);
  assign lb    = PAW'(fin.len_b);

  assign in_a      = (pa > -ea) && (pa < la);
  assign in_a_wide = (pa > -ea) && (pa < la + ea);
  assign in_b      = (pb > -eb) && (pb < lb);

  always_comb begin
    unique case (test_mode)
      sgi3_pkg::MODE_LINE:     hit_next = fin.close;
      sgi3_pkg::MODE_SEG_LINE: hit_next = fin.close && in_a_wide;
      default:                 hit_next = fin.close && in_a && in_b;
    endcase
  end

  // clamp to 32-bit Q16.16
  always_comb begin
    if (pa[PAW-1:sgi3_pkg::PARAM_W-1] == '0 || pa[PAW-1:sgi3_pkg::PARAM_W-1] == '1) begin
      sat_a = pa[sgi3_pkg::PARAM_W-1:0];
    end else begin
      sat_a = pa[PAW-1] ? {1'b1, (sgi3_pkg::PARAM_W-1)'(0)} : {1'b0, {(sgi3_pkg::PARAM_W-1){1'b1}}};
    end
    if (pb[PAW-1:sgi3_pkg::PARAM_W-1] == '0 || pb[PAW-1:sgi3_pkg::PARAM_W-1] == '1) begin
      sat_b = pb[sgi3_pkg::PARAM_W-1:0];
    end else begin
      sat_b = pb[PAW-1] ? {1'b1, (sgi3_pkg::PARAM_W-1)'(0)} : {1'b0, {(sgi3_pkg::PARAM_W-1){1'b1}}};
    end
  end

  // output register; a degenerate pair reports nothing but the flag
  always_ff @(posedge clk) begin
    if (adv) begin
      degenerate  <= fin.degen;
      hit         <= hit_next && !fin.degen;
      lines_close <= fin.close && !fin.degen;
      param_a     <= fin.degen ? '0 : sat_a;
      param_b     <= fin.degen ? '0 : sat_b;
    end
  end

  // checks
  a_degen_quiet : assert property (@(posedge clk) disable iff (rst)
    out_valid && degenerate |-> !hit && !lines_close && param_a == '0 && param_b == '0)
    else $error("degenerate result carries hit, close or parameters");

  a_hit_close : assert property (@(posedge clk) disable iff (rst)
    out_valid && hit |-> lines_close)
    else $error("hit without close lines");

  a_reset_empty : assert property (@(posedge clk)
    $past(rst) |-> !out_valid)
    else $error("result valid right after reset");

endmodule

// ----- verif/segment_intersect_3d_checker.sv -----
`timescale 1ns / 1ps
// closest-approach checker: predicts each result and compares the output transfers
module segment_intersect_3d_checker (
  input  logic                               clk,
  input  logic                               rst,
  input  logic                               in_valid,
  input  logic                               in_stall,
  input  logic [11:0][15:0]                  coord,
  input  logic                               out_valid,
  input  logic                               out_stall,
  input  logic                               hit,
  input  logic                               lines_close,
  input  logic                               degenerate,
  input  logic signed [sgi3_pkg::PARAM_W-1:0] param_a,
  input  logic signed [sgi3_pkg::PARAM_W-1:0] param_b,
  input  logic                               cfg_we,
  input  logic [sgi3_pkg::CFG_IDX_W-1:0]     cfg_index,
  input  logic [sgi3_pkg::TOL_W-1:0]         cfg_data,
  output int                                 outstanding,
  output int                                 mismatches
);

  typedef logic signed [255:0] wide_t;

  typedef struct packed {
    logic                                hit;
    logic                                close;
    logic                                degen;
    logic signed [sgi3_pkg::PARAM_W-1:0] pa;
    logic signed [sgi3_pkg::PARAM_W-1:0] pb;
  } approach_t;

  logic [sgi3_pkg::MODE_W-1:0] mode_q;
  logic [sgi3_pkg::TOL_W-1:0]  tol_a_q, tol_b_q;
  approach_t                   approach_q[$];

  function automatic wide_t root_floor(input wide_t x);
    wide_t r, c;
    r = 0;
    for (int b = 62; b >= 0; b--) begin
      c = r | (wide_t'(1) << b);
      if (c * c <= x) r = c;
    end
    return r;
  endfunction

  function automatic wide_t scaled_param(input wide_t num, input wide_t len, input wide_t nn);
    wide_t v;
    v = ((num < 0) ? -num : num) * len / nn;
    if (v > (wide_t'(1) << 62)) v = wide_t'(1) << 62;
    return (num < 0) ? -v : v;
  endfunction

  function automatic logic signed [31:0] sat32(input wide_t v);
    if (v > 64'sd2147483647) return 32'sh7fffffff;
    if (v < -64'sd2147483648) return 32'sh80000000;
    return v[31:0];
  endfunction

  function automatic approach_t predict_approach(input logic [11:0][15:0] c,
                                                 input logic [sgi3_pkg::MODE_W-1:0] mode,
                                                 input logic [sgi3_pkg::TOL_W-1:0] tol_a,
                                                 input logic [sgi3_pkg::TOL_W-1:0] tol_b);
    wide_t oa[3], da[3], ob[3], db[3], w[3], n[3], ca[3], cb[3];
    wide_t nn, nw, num_a, num_b, eps, len_a, len_b, pa, pb, ea, eb;
    approach_t r;
    logic close, in_a, in_b;
    for (int i = 0; i < 3; i++) begin
      oa[i] = $signed(c[i]);
      da[i] = $signed(c[3+i]);
      ob[i] = $signed(c[6+i]);
      db[i] = $signed(c[9+i]);
      w[i]  = ob[i] - oa[i];
    end
    for (int i = 0; i < 3; i++) begin
      n[i]  = da[sgi3_pkg::NEXT1[i]] * db[sgi3_pkg::NEXT2[i]] -
              da[sgi3_pkg::NEXT2[i]] * db[sgi3_pkg::NEXT1[i]];
      cb[i] = w[sgi3_pkg::NEXT1[i]] * db[sgi3_pkg::NEXT2[i]] -
              w[sgi3_pkg::NEXT2[i]] * db[sgi3_pkg::NEXT1[i]];
      ca[i] = w[sgi3_pkg::NEXT1[i]] * da[sgi3_pkg::NEXT2[i]] -
              w[sgi3_pkg::NEXT2[i]] * da[sgi3_pkg::NEXT1[i]];
    end
    nn = n[0]*n[0] + n[1]*n[1] + n[2]*n[2];
    r = '0;
    if (nn == 0) begin
      // parallel or zero directions
      r.degen = 1'b1;
      return r;
    end
    nw    = n[0]*w[0] + n[1]*w[1] + n[2]*w[2];
    eps   = wide_t'(tol_a) + wide_t'(tol_b);
    close = (nw * nw) < (eps * eps * nn);
    num_a = cb[0]*n[0] + cb[1]*n[1] + cb[2]*n[2];
    num_b = ca[0]*n[0] + ca[1]*n[1] + ca[2]*n[2];
    len_a = root_floor((da[0]*da[0] + da[1]*da[1] + da[2]*da[2]) <<< 16);
    len_b = root_floor((db[0]*db[0] + db[1]*db[1] + db[2]*db[2]) <<< 16);
    pa    = scaled_param(num_a, len_a, nn);
    pb    = scaled_param(num_b, len_b, nn);
    ea    = wide_t'(tol_a) <<< 8;
    eb    = wide_t'(tol_b) <<< 8;
    in_a  = (pa > -ea) && (pa < len_a);
    in_b  = (pb > -eb) && (pb < len_b);
    case (mode)
      sgi3_pkg::MODE_LINE:     r.hit = close;
      sgi3_pkg::MODE_SEG_LINE: r.hit = close && (pa > -ea) && (pa < len_a + ea);
      default:                 r.hit = close && in_a && in_b;  // unused code acts as segment/segment
    endcase
    r.close = close;
    r.pa    = sat32(pa);
    r.pb    = sat32(pb);
    return r;
  endfunction

  always @(posedge clk) begin
    approach_t e;
    if (rst) begin
      mode_q      <= sgi3_pkg::MODE_RESET;
      tol_a_q     <= sgi3_pkg::TOL_FIRST_RESET;
      tol_b_q     <= sgi3_pkg::TOL_SECOND_RESET;
      approach_q.delete();
      outstanding <= 0;
      mismatches  <= 0;
    end else begin
      if (cfg_we) begin
        case (cfg_index)
          sgi3_pkg::REG_TEST_MODE:  mode_q  <= cfg_data[sgi3_pkg::MODE_W-1:0];
          sgi3_pkg::REG_TOL_FIRST:  tol_a_q <= cfg_data;
          sgi3_pkg::REG_TOL_SECOND: tol_b_q <= cfg_data;
          default: ;
        endcase
      end
      if (in_valid && !in_stall)
        approach_q.insert(approach_q.size(),
                          predict_approach(coord, mode_q, tol_a_q, tol_b_q));
      if (out_valid && !out_stall) begin
        if (approach_q.size() == 0) begin
          if (mismatches < 10) $display("unexpected result transfer at %0t", $time);
          mismatches <= mismatches + 1;
        end else begin
          e = approach_q.pop_front();
          if (e.hit !== hit || e.close !== lines_close || e.degen !== degenerate ||
              e.pa !== param_a || e.pb !== param_b) begin
            if (mismatches < 10)
              $display({"mismatch at %0t: exp hit %b close %b degen %b pa %h pb %h,",
                        " got %b %b %b %h %h"},
                       $time, e.hit, e.close, e.degen, e.pa, e.pb,
                       hit, lines_close, degenerate, param_a, param_b);
            mismatches <= mismatches + 1;
          end
        end
      end
      outstanding <= approach_q.size();
    end
  end

endmodule

// ----- verif/segment_intersect_3d_test.sv -----
`timescale 1ns / 1ps
// testbench top: stimulus, flow control and verdict for segment_intersect_3d
module segment_intersect_3d_test;

  localparam int LATENCY   = 63;
  localparam int WDOG_MAX  = 20000;   // cycles without any transfer
  localparam int HOLD_LONG = 400;     // long receiver hold-off

  logic                                clk;
  logic                                rst;
  logic                                in_valid;
  logic                                in_stall;
  logic [11:0][15:0]                   coord;
  logic                                out_valid;
  logic                                out_stall;
  logic                                hit, lines_close, degenerate;
  logic signed [sgi3_pkg::PARAM_W-1:0] param_a, param_b;
  logic                                cfg_we;
  logic [sgi3_pkg::CFG_IDX_W-1:0]      cfg_index;
  logic [sgi3_pkg::TOL_W-1:0]          cfg_data;
  int                                  outstanding, mismatches;

  int send_idle_pct;   // chance of an idle cycle before each item
  int stall_pct;       // chance the receiver stalls in a cycle
  bit hold_request;    // asks the receiver for a long hold-off
  int wdog;

  segment_intersect_3d uut (
    .clk, .rst, .in_valid, .in_stall,
    .a_origin_x(coord[0]), .a_origin_y(coord[1]), .a_origin_z(coord[2]),
    .a_dir_x(coord[3]),    .a_dir_y(coord[4]),    .a_dir_z(coord[5]),
    .b_origin_x(coord[6]), .b_origin_y(coord[7]), .b_origin_z(coord[8]),
    .b_dir_x(coord[9]),    .b_dir_y(coord[10]),   .b_dir_z(coord[11]),
    .out_valid, .out_stall, .hit, .lines_close, .degenerate, .param_a, .param_b,
    .cfg_we, .cfg_index, .cfg_data
  );

  segment_intersect_3d_checker checker_i (
    .clk, .rst, .in_valid, .in_stall, .coord, .out_valid, .out_stall,
    .hit, .lines_close, .degenerate, .param_a, .param_b,
    .cfg_we, .cfg_index, .cfg_data, .outstanding, .mismatches
  );

  initial begin
    clk = 1'b0;
    forever #5 clk = ~clk;
  end

  // receiver: random stalls, or a long hold-off counted here when asked
  initial begin
    int hold_left;
    hold_left = 0;
    out_stall = 1'b0;
    forever begin
      @(posedge clk);
      if (hold_request) begin
        hold_left    = HOLD_LONG;
        hold_request = 1'b0;
      end
      if (hold_left > 0) begin
        out_stall <= 1'b1;
        hold_left--;
      end else begin
        out_stall <= ($urandom_range(99) < stall_pct);
      end
    end
  end

  // watchdog: cycles with no transfer on either channel
  always @(posedge clk) begin
    if (rst || (in_valid && !in_stall) || (out_valid && !out_stall)) begin
      wdog <= 0;
    end else begin
      wdog <= wdog + 1;
      if (wdog >= WDOG_MAX) begin
        $display("TB_ERROR");
        $finish;
      end
    end
  end

  // offer one item and hold it until the transfer
  task automatic offer(input logic [11:0][15:0] v);
    while ($urandom_range(99) < send_idle_pct) begin
      in_valid <= 1'b0;
      @(posedge clk);
    end
    coord    <= v;
    in_valid <= 1'b1;
    @(posedge clk);
    while (in_stall) @(posedge clk);
  endtask

  // stop offering and let the pipeline empty out
  task automatic drain();
    in_valid <= 1'b0;
    @(posedge clk);
    while (outstanding != 0) @(posedge clk);
    repeat (LATENCY + 8) @(posedge clk);
  endtask

  task automatic write_regs(input logic [sgi3_pkg::MODE_W-1:0] mode,
                            input logic [sgi3_pkg::TOL_W-1:0] tol_a,
                            input logic [sgi3_pkg::TOL_W-1:0] tol_b);
    cfg_we    <= 1'b1;
    cfg_index <= sgi3_pkg::REG_TEST_MODE;
    cfg_data  <= sgi3_pkg::TOL_W'(mode);
    @(posedge clk);
    cfg_index <= sgi3_pkg::REG_TOL_FIRST;
    cfg_data  <= tol_a;
    @(posedge clk);
    cfg_index <= sgi3_pkg::REG_TOL_SECOND;
    cfg_data  <= tol_b;
    @(posedge clk);
    cfg_we    <= 1'b0;
  endtask

  function automatic logic [11:0][15:0] pack_lines(input int ax, ay, az, adx, ady, adz,
                                                   input int bx, by, bz, bdx, bdy, bdz);
    return {16'(bdz), 16'(bdy), 16'(bdx), 16'(bz), 16'(by), 16'(bx),
            16'(adz), 16'(ady), 16'(adx), 16'(az), 16'(ay), 16'(ax)};
  endfunction

  // random item: mostly lines that cross near a common point, some parallel, some noise
  function automatic logic [11:0][15:0] random_lines();
    logic [11:0][15:0] v;
    int p[3], da[3], db[3], ta, tb, k, sel;
    sel = $urandom_range(99);
    if (sel < 20) begin
      for (int i = 0; i < 12; i++) v[i] = 16'($urandom);
      return v;
    end
    for (int i = 0; i < 3; i++) begin
      p[i]  = $urandom_range(4000) - 2000;
      da[i] = $urandom_range(512) - 256;
      db[i] = $urandom_range(512) - 256;
    end
    ta = $urandom_range(4) - 1;
    tb = $urandom_range(4) - 1;
    if (sel < 30) begin
      // parallel second direction
      k = $urandom_range(3) - 1;
      for (int i = 0; i < 3; i++) db[i] = k * da[i];
    end
    for (int i = 0; i < 3; i++) begin
      v[i]   = 16'(p[i] - ta * da[i]);
      v[3+i] = 16'(da[i]);
      v[6+i] = 16'(p[i] - tb * db[i] + (sel < 60 ? int'($urandom_range(8)) - 4 : 0));
      v[9+i] = 16'(db[i]);
    end
    return v;
  endfunction

  task automatic random_phase(input int items, input int idle, input int stall);
    send_idle_pct = idle;
    stall_pct     = stall;
    for (int i = 0; i < items; i++) offer(random_lines());
  endtask

  initial begin
    rst           = 1'b1;
    in_valid      = 1'b0;
    coord         = '0;
    cfg_we        = 1'b0;
    cfg_index     = sgi3_pkg::REG_TEST_MODE;
    cfg_data      = '0;
    send_idle_pct = 0;
    stall_pct     = 0;
    hold_request  = 1'b0;
    repeat (7) @(posedge clk);
    rst <= 1'b0;
    @(posedge clk);

    // directed part at reset settings (segment/segment)
    offer(pack_lines(0, 0, 0, 256, 0, 0, 128, -128, 0, 0, 256, 0));       // crossing segments
    offer(pack_lines(0, 0, 0, 256, 0, 0, 128, -128, 256, 0, 256, 0));     // skew, far apart
    offer(pack_lines(0, 0, 0, 256, 0, 0, 0, 5, 0, 512, 0, 0));            // parallel
    offer(pack_lines(1, 2, 3, 0, 0, 0, 4, 5, 6, 7, 8, 9));                // zero direction
    offer(pack_lines(0, 0, 0, 256, 0, 0, 1024, -128, 0, 0, 256, 0));      // beyond segment end
    offer(pack_lines(-32768, -32768, -32768, 32767, -32768, 32767,
                     32767, 32767, 32767, -32768, 32767, 1));             // extremes
    offer(pack_lines(32767, -32768, 0, 1, 32767, -32768,
                     -32768, 32767, -1, 32767, -1, 32767));
    offer(pack_lines(0, 0, 0, 1, 0, 0, 0, 0, 0, 0, 1, 0));                // tiny directions
    offer(pack_lines(0, 0, 0, 32767, 0, 0, -32768, 0, 0, 0, 0, 32767));
    drain();
    // line/line with huge tolerances
    write_regs(sgi3_pkg::MODE_LINE, 16'hffff, 16'hffff);
    offer(pack_lines(0, 0, 0, 256, 0, 0, 128, -128, 256, 0, 256, 0));
    offer(pack_lines(-32768, 0, 0, 256, 1, 0, 32767, 0, 0, 0, 1, 256));
    offer(pack_lines(0, 0, 0, 256, 0, 0, 0, 5, 0, -256, 0, 0));
    drain();
    // segment/line with zero tolerances
    write_regs(sgi3_pkg::MODE_SEG_LINE, 16'h0000, 16'h0000);
    offer(pack_lines(0, 0, 0, 256, 0, 0, 128, -128, 0, 0, 256, 0));
    offer(pack_lines(0, 0, 0, 256, 0, 0, -256, -128, 0, 0, 256, 0));
    offer(pack_lines(0, 0, 0, 256, 0, 0, 128, -128, 1, 0, 256, 0));
    drain();
    // unused mode code, and a write to an index with no register
    write_regs(sgi3_pkg::MODE_SEG_SEG + 2'd1, 16'd16, 16'd0);
    cfg_we    <= 1'b1;
    cfg_index <= sgi3_pkg::REG_TOL_SECOND + 2'd1;
    cfg_data  <= 16'hffff;
    @(posedge clk);
    cfg_we    <= 1'b0;
    offer(pack_lines(0, 0, 0, 256, 0, 0, 128, -128, 2, 0, 256, 0));
    offer(pack_lines(0, 0, 0, 256, 0, 0, 300, -128, 0, 0, 256, 0));
    offer(pack_lines(0, 0, 0, 256, 0, 0, 128, 300, 0, 0, 256, 0));
    drain();

    // random part, one setting per phase
    write_regs(sgi3_pkg::MODE_LINE, 16'd8, 16'd8);
    random_phase(100, 0, 0);
    // long receiver hold-off while items keep coming, then a full pause
    hold_request = 1'b1;
    random_phase(40, 0, 0);
    drain();
    write_regs(sgi3_pkg::MODE_SEG_LINE, 16'd2, 16'd40);
    random_phase(100, 59, 0);
    drain();
    write_regs(sgi3_pkg::MODE_SEG_SEG, 16'd4, 16'd4);
    random_phase(100, 0, 59);
    drain();
    write_regs(sgi3_pkg::MODE_SEG_SEG + 2'd1, 16'hffff, 16'd1);
    random_phase(100, 31, 31);
    drain();
    write_regs(sgi3_pkg::MODE_SEG_LINE, 16'd0, 16'hffff);
    random_phase(60, 0, 0);

    // wait for the last results, then a little longer
    drain();
    if (mismatches == 0 && outstanding == 0) begin
      $display("TB_OK");
    end else begin
      $display("TB_ERROR");
    end
    $finish;
  end

endmodule

// ----- filelist.f -----
sv/sgi3_pkg.sv
sv/sgi3_div.sv
sv/segment_intersect_3d.sv
verif/segment_intersect_3d_checker.sv
verif/segment_intersect_3d_test.sv
